[hdl/bmphdr_pkg.sv]
package bmphdr_pkg;

   // field widths
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned DEPTH_W = 16;

   // signature bytes
   localparam logic [BYTE_W-1:0] SIG_B = 8'h42;
   localparam logic [BYTE_W-1:0] SIG_M = 8'h4D;

   // header layout
   localparam logic [WORD_W-1:0] CHECK_LEN      = 32'd26;
   localparam logic [WORD_W-1:0] MIN_OFFSET     = 32'd14;
   localparam logic [WORD_W-1:0] CORE_DIB_SIZE  = 32'd12;
   localparam logic [WORD_W-1:0] INFO_DIB_SIZE  = 32'd40;
   localparam logic [WORD_W-1:0] INFO_HDR_END   = 32'd54;

   typedef enum logic [1:0] {
      VERDICT_NO_MATCH  = 2'd0,
      VERDICT_PARTIAL   = 2'd1,
      VERDICT_TRUNCATED = 2'd2,
      VERDICT_MATCHED   = 2'd3
   } verdict_type;

   typedef enum logic {
      PH_IDLE   = 1'b0,
      PH_ACTIVE = 1'b1
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              first_byte;
      logic              last_byte;
   } req_item_type;

   typedef struct packed {
      verdict_type        verdict;
      logic [WORD_W-1:0]  match_length;
      logic [WORD_W-1:0]  declared_size;
      logic [WORD_W-1:0]  data_offset;
      logic [WORD_W-1:0]  dib_size;
      logic [WORD_W-1:0]  image_width;
      logic [WORD_W-1:0]  image_height;
      logic [DEPTH_W-1:0] bits_per_pixel;
      logic [WORD_W-1:0]  compression;
      logic               top_down;
   } rsp_item_type;

endpackage

[hdl/bmphdr_if.sv]
interface bmphdr_req_if;
   logic                               valid;
   logic                               ready;
   logic [bmphdr_pkg::BYTE_W-1:0]      data_byte;
   logic                               first_byte;
   logic                               last_byte;

   modport source (output valid, output data_byte, output first_byte, output last_byte,
                   input ready);
   modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                   output ready);
endinterface

interface bmphdr_rsp_if;
   logic                               valid;
   logic                               ready;
   bmphdr_pkg::verdict_type            verdict;
   logic [bmphdr_pkg::WORD_W-1:0]      match_length;
   logic [bmphdr_pkg::WORD_W-1:0]      declared_size;
   logic [bmphdr_pkg::WORD_W-1:0]      data_offset;
   logic [bmphdr_pkg::WORD_W-1:0]      dib_size;
   logic [bmphdr_pkg::WORD_W-1:0]      image_width;
   logic [bmphdr_pkg::WORD_W-1:0]      image_height;
   logic [bmphdr_pkg::DEPTH_W-1:0]     bits_per_pixel;
   logic [bmphdr_pkg::WORD_W-1:0]      compression;
   logic                               top_down;

   modport source (output valid, output verdict, output match_length, output declared_size,
                   output data_offset, output dib_size, output image_width,
                   output image_height, output bits_per_pixel, output compression,
                   output top_down, input ready);
   modport sink   (input valid, input verdict, input match_length, input declared_size,
                   input data_offset, input dib_size, input image_width,
                   input image_height, input bits_per_pixel, input compression,
                   input top_down, output ready);
endinterface

[hdl/bmphdr_step.sv]
module bmphdr_step (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   input  bmphdr_pkg::req_item_type item,
   output logic                     result_valid,
   output bmphdr_pkg::rsp_item_type result
);
   import bmphdr_pkg::*;

   // or one byte into its little-endian lane
   function automatic logic [WORD_W-1:0] put_le(input logic [WORD_W-1:0] field,
                                                input logic [BYTE_W-1:0] b,
                                                input logic [5:0] idx,
                                                input logic [5:0] base);
      logic [1:0] lane;
      lane = 2'(idx - base);
      return field | ({24'd0, b} << {lane, 3'b000});
   endfunction

   phase_type          phase_ff, phase_in;
   logic [WORD_W-1:0]  byte_count_ff;
   logic [WORD_W-1:0]  size_ff, offset_ff, dib_ff, width_ff, height_ff, comp_ff;
   logic [DEPTH_W-1:0] depth_ff;

   logic               active;
   logic [WORD_W-1:0]  cnt_base, size_base, offset_base, dib_base;
   logic [WORD_W-1:0]  width_base, height_base, comp_base;
   logic [DEPTH_W-1:0] depth_base;
   logic [WORD_W-1:0]  size_in, offset_in, dib_in, width_in, height_in, comp_in;
   logic [DEPTH_W-1:0] depth_in;
   logic [WORD_W-1:0]  count_in;
   logic [5:0]         idx;
   logic               idx_low;

   logic               fin, hdr, check_fail;
   verdict_type        verdict;
   logic [WORD_W-1:0]  length, hend, fend;
   logic               is_core, is_info, neg;

   // a start mark restarts from cleared fields
   assign active = item.first_byte || (phase_ff == PH_ACTIVE);

   always_comb begin
      cnt_base    = item.first_byte ? '0 : byte_count_ff;
      size_base   = item.first_byte ? '0 : size_ff;
      offset_base = item.first_byte ? '0 : offset_ff;
      dib_base    = item.first_byte ? '0 : dib_ff;
      width_base  = item.first_byte ? '0 : width_ff;
      height_base = item.first_byte ? '0 : height_ff;
      comp_base   = item.first_byte ? '0 : comp_ff;
      depth_base  = item.first_byte ? '0 : depth_ff;
   end

   assign idx      = cnt_base[5:0];
   assign idx_low  = (cnt_base[WORD_W-1:6] == '0);
   assign count_in = cnt_base + 32'd1;

   // header field capture by byte position
   always_comb begin
      size_in   = size_base;
      offset_in = offset_base;
      dib_in    = dib_base;
      width_in  = width_base;
      height_in = height_base;
      comp_in   = comp_base;
      depth_in  = depth_base;
      if (idx_low) begin
         priority if (idx >= 6'd2 && idx <= 6'd5) begin
            size_in = put_le(size_base, item.data_byte, idx, 6'd2);
         end else if (idx >= 6'd10 && idx <= 6'd13) begin
            offset_in = put_le(offset_base, item.data_byte, idx, 6'd10);
         end else if (idx >= 6'd14 && idx <= 6'd17) begin
            dib_in = put_le(dib_base, item.data_byte, idx, 6'd14);
         end else if (dib_base == CORE_DIB_SIZE) begin
            priority if (idx == 6'd18 || idx == 6'd19) begin
               width_in = put_le(width_base, item.data_byte, idx, 6'd18);
            end else if (idx == 6'd20 || idx == 6'd21) begin
               height_in = put_le(height_base, item.data_byte, idx, 6'd20);
            end else if (idx == 6'd24 || idx == 6'd25) begin
               depth_in = DEPTH_W'(put_le({16'd0, depth_base}, item.data_byte, idx, 6'd24));
            end else begin
               depth_in = depth_base;
            end
         end else if (dib_base >= INFO_DIB_SIZE) begin
            priority if (idx >= 6'd18 && idx <= 6'd21) begin
               width_in = put_le(width_base, item.data_byte, idx, 6'd18);
            end else if (idx >= 6'd22 && idx <= 6'd25) begin
               height_in = put_le(height_base, item.data_byte, idx, 6'd22);
            end else if (idx == 6'd28 || idx == 6'd29) begin
               depth_in = DEPTH_W'(put_le({16'd0, depth_base}, item.data_byte, idx, 6'd28));
            end else if (idx >= 6'd30 && idx <= 6'd33) begin
               comp_in = put_le(comp_base, item.data_byte, idx, 6'd30);
            end else begin
               comp_in = comp_base;
            end
         end else begin
            dib_in = dib_base;
         end
      end
   end

   // sanity checks and end points
   assign check_fail = (size_in < CHECK_LEN) || (offset_in < MIN_OFFSET) ||
                       (dib_in < CORE_DIB_SIZE) || (offset_in > size_in);
   assign hend = (dib_in >= INFO_DIB_SIZE) ? INFO_HDR_END : CHECK_LEN;
   assign fend = (size_in > hend) ? size_in : hend;

   // verdict decision for this byte
   always_comb begin
      fin     = 1'b0;
      hdr     = 1'b0;
      verdict = VERDICT_NO_MATCH;
      length  = '0;
      priority if (cnt_base == 32'd0) begin
         fin = (item.data_byte != SIG_B) || item.last_byte;
      end else if (cnt_base == 32'd1) begin
         if (item.data_byte != SIG_M) begin
            fin = 1'b1;
         end else if (item.last_byte) begin
            fin     = 1'b1;
            verdict = VERDICT_PARTIAL;
         end
      end else if (count_in < CHECK_LEN) begin
         if (item.last_byte) begin
            fin     = 1'b1;
            verdict = VERDICT_PARTIAL;
         end
      end else if (count_in == CHECK_LEN && check_fail) begin
         fin = 1'b1;
      end else if (count_in >= fend || item.last_byte) begin
         fin = 1'b1;
         hdr = 1'b1;
         if (count_in >= size_in) begin
            verdict = VERDICT_MATCHED;
            length  = size_in;
         end else begin
            verdict = VERDICT_TRUNCATED;
            length  = count_in;
         end
      end
   end

   // phase next state
   always_comb begin
      phase_in = phase_ff;
      if (item_valid && active) begin
         phase_in = fin ? PH_IDLE : PH_ACTIVE;
      end
   end

   // result fields
   assign is_core = (dib_in == CORE_DIB_SIZE);
   assign is_info = (dib_in >= INFO_DIB_SIZE) && (count_in >= INFO_HDR_END);
   assign neg     = height_in[WORD_W-1];

   always_comb begin
      result_valid          = item_valid && active && fin;
      result                = '0;
      result.verdict        = verdict;
      result.match_length   = length;
      if (hdr) begin
         result.declared_size = size_in;
         result.data_offset   = offset_in;
         result.dib_size      = dib_in;
         result.top_down      = 1'b1;
         if (is_core) begin
            result.image_width    = {16'd0, width_in[15:0]};
            result.image_height   = {16'd0, height_in[15:0]};
            result.bits_per_pixel = depth_in;
         end else if (is_info) begin
            result.image_width    = width_in;
            result.image_height   = neg ? (32'd0 - height_in) : height_in;
            result.bits_per_pixel = depth_in;
            result.compression    = comp_in;
            result.top_down       = neg;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid && active) begin
         byte_count_ff <= count_in;
         size_ff       <= size_in;
         offset_ff     <= offset_in;
         dib_ff        <= dib_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         depth_ff      <= depth_in;
         comp_ff       <= comp_in;
      end
   end

`ifndef SYNTHESIS
   a_idle_after_verdict: assert property (@(posedge clock) disable iff (reset)
      result_valid |=> (phase_ff == PH_IDLE))
      else $error("parser not idle after a verdict");

   a_no_verdict_when_idle: assert property (@(posedge clock) disable iff (reset)
      (item_valid && !item.first_byte && phase_ff == PH_IDLE) |-> !result_valid)
      else $error("verdict from an unmarked byte while idle");

   a_count_restart: assert property (@(posedge clock) disable iff (reset)
      (item_valid && item.first_byte) |=> (byte_count_ff == 32'd1))
      else $error("byte count not restarted by a start mark");
`endif

endmodule

[hdl/bmp_header_recognizer_top.sv]
// path: an accepted item waits in the input register, passes the parse step, and any
//   result it yields is held in the result register until the sink takes it
// throughput: one byte per cycle while the result register is not held; the per-byte
//   parse step sits between the input and result registers and keeps up each cycle
// backpressure stalls the input register only while the result register is held
// reset: synchronous, active high; clears valid flags and sets the parser idle
module bmp_header_recognizer_top (
   input  logic        clock,
   input  logic        reset,
   bmphdr_req_if.sink  req_chan,
   bmphdr_rsp_if.source rsp_chan
);
   import bmphdr_pkg::*;

   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;

   logic         out_free, step_fire, req_fire;
   logic         step_valid;
   rsp_item_type step_result;

   // handshake
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign step_fire = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_fire  = req_chan.valid && req_chan.ready;

   // input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (step_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff.data_byte  <= req_chan.data_byte;
         s1_item_ff.first_byte <= req_chan.first_byte;
         s1_item_ff.last_byte  <= req_chan.last_byte;
      end
   end

   // parse step
   bmphdr_step u_step (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (step_fire),
      .item         (s1_item_ff),
      .result_valid (step_valid),
      .result       (step_result)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step_fire && step_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire && step_valid) begin
         rsp_item_ff <= step_result;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.verdict        = rsp_item_ff.verdict;
   assign rsp_chan.match_length   = rsp_item_ff.match_length;
   assign rsp_chan.declared_size  = rsp_item_ff.declared_size;
   assign rsp_chan.data_offset    = rsp_item_ff.data_offset;
   assign rsp_chan.dib_size       = rsp_item_ff.dib_size;
   assign rsp_chan.image_width    = rsp_item_ff.image_width;
   assign rsp_chan.image_height   = rsp_item_ff.image_height;
   assign rsp_chan.bits_per_pixel = rsp_item_ff.bits_per_pixel;
   assign rsp_chan.compression    = rsp_item_ff.compression;
   assign rsp_chan.top_down       = rsp_item_ff.top_down;

`ifndef SYNTHESIS
   a_stalled_item_kept: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> s1_valid_ff)
      else $error("buffered item dropped during a stall");

   a_short_verdict_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_item_ff.verdict == VERDICT_NO_MATCH ||
                        rsp_item_ff.verdict == VERDICT_PARTIAL))
      |-> (rsp_item_ff.match_length == '0 && rsp_item_ff.declared_size == '0))
      else $error("non-match verdict carries header values");

   a_match_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.verdict == VERDICT_MATCHED)
      |-> (rsp_item_ff.match_length == rsp_item_ff.declared_size))
      else $error("matched length differs from declared size");
`endif

endmodule
